// ----- hdl/gpmt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gpmt_pkg
// Shared types, constants and helpers of the ground plane merge table.
// ----------------------------------------------------------------------------
package gpmt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int SIZE_W      = $clog2(TABLE_DEPTH + 1);

   localparam logic [31:0] COUNT_CAP = 32'd100000000;

   localparam logic [1:0] ST_APPEND = 2'd0;
   localparam logic [1:0] ST_MERGE  = 2'd1;
   localparam logic [1:0] ST_DROP   = 2'd2;
   localparam logic [1:0] ST_POSE   = 2'd3;

   localparam logic [1:0] CSR_MATCH_DIST = 2'd0;
   localparam logic [1:0] CSR_MATCH_COS  = 2'd1;
   localparam logic [1:0] CSR_OUTLIER    = 2'd2;

   typedef struct packed {
      logic [31:0]       points;
      logic [2:0][31:0]  normal;
      logic [2:0][31:0]  center;
   } plane_entry_type;

   localparam int ENTRY_W = $bits(plane_entry_type);

   localparam logic signed [67:0] SAT_HI = 68'sh7fffffff;
   localparam logic signed [67:0] SAT_LO = -68'sh80000000;

   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      if (v > SAT_HI) begin
         sat32 = 32'sh7fffffff;
      end else if (v < SAT_LO) begin
         sat32 = -32'sh80000000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

endpackage
`default_nettype wire

// ----- hdl/gpmt_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gpmt_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module gpmt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ----- hdl/ground_plane_merge_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ground_plane_merge_table
// Table of ground planes merged from pose-transformed plane observations.
//
// req_*: one word per item, kind 0 loads a pose row, kind 1 is a plane.
// rsp_*: one word per item: status, touched entry, outlier erase, table size.
// csr_*: register writes (match distance, match cosine, outlier count),
//        always ready, to be written while the block is idle.
// A plane word is transformed by the pose, then scans the stored entries
// in order; a merge or append is followed by the outlier check.
// The merge cost is set by the bit-serial divider, 64 quotient bits each,
// used for up to nine quotients, and a 32-step square root.
// One item is processed at a time; the next word is taken once the result
// is parked in the output register, so a stalled receiver holds at most one
// finished word while the next item runs.
// Reset empties the table, loads the identity pose and the default
// thresholds. The table RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module ground_plane_merge_table (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_kind,
   input  wire logic [1:0]         req_pose_row,
   input  wire logic signed [31:0] req_value_a,
   input  wire logic signed [31:0] req_value_b,
   input  wire logic signed [31:0] req_value_c,
   input  wire logic signed [31:0] req_value_d,
   input  wire logic signed [31:0] req_value_e,
   input  wire logic signed [31:0] req_value_f,
   input  wire logic [30:0]        req_point_count,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_status,
   output logic [3:0]              rsp_entry_index,
   output logic                    rsp_removed_flag,
   output logic [3:0]              rsp_removed_index,
   output logic [4:0]              rsp_table_size,
   output logic [31:0]             rsp_entry_count,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data
);

   import gpmt_pkg::*;

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_XFORM   = 5'd1;
   localparam logic [4:0] S_SCAN_RD = 5'd2;
   localparam logic [4:0] S_SCAN_LD = 5'd3;
   localparam logic [4:0] S_MATCH   = 5'd4;
   localparam logic [4:0] S_BMUL    = 5'd5;
   localparam logic [4:0] S_BDIVS   = 5'd6;
   localparam logic [4:0] S_DIV     = 5'd7;
   localparam logic [4:0] S_DIVFIN  = 5'd8;
   localparam logic [4:0] S_SQ      = 5'd9;
   localparam logic [4:0] S_SQRT    = 5'd10;
   localparam logic [4:0] S_NSET    = 5'd11;
   localparam logic [4:0] S_WB      = 5'd12;
   localparam logic [4:0] S_APPEND  = 5'd13;
   localparam logic [4:0] S_ORD     = 5'd14;
   localparam logic [4:0] S_OWAIT   = 5'd15;
   localparam logic [4:0] S_OCHK    = 5'd16;
   localparam logic [4:0] S_EWAIT   = 5'd17;
   localparam logic [4:0] S_EWR     = 5'd18;
   localparam logic [4:0] S_DONE    = 5'd19;

   logic [4:0]               state_ff;
   logic signed [31:0]       rot_ff [9];
   logic signed [31:0]       trans_ff [3];
   logic [30:0]              md_ff;
   logic [16:0]              mc_ff;
   logic [30:0]              oc_ff;
   logic signed [31:0]       vin_ff [6];
   logic [30:0]              np_ff;
   logic signed [31:0]       wc_ff [3];
   logic signed [31:0]       wn_ff [3];
   plane_entry_type          ent_ff;
   logic [SIZE_W-1:0]        valid_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic [IDX_W-1:0]         rd_addr_ff;
   logic [2:0]               grp_ff;
   logic [2:0]               cnt_ff;
   logic [2:0]               m_ff;
   logic signed [65:0]       mul_ff;
   logic signed [51:0]       acc_ff;
   logic [51:0]              dist_ff;
   logic [63:0]              div_q_ff;
   logic [33:0]              div_r_ff;
   logic [33:0]              div_d_ff;
   logic                     div_neg_ff;
   logic signed [31:0]       base_ff;
   logic                     norm_ff;
   logic [5:0]               it_ff;
   logic [63:0]              sq_ff;
   logic [63:0]              res_ff;
   logic [63:0]              bit_ff;
   logic [32:0]              wsum_ff;
   logic [1:0]               status_ff;
   logic                     rem_ff;
   logic [IDX_W-1:0]         rem_idx_ff;
   logic [31:0]              ecount_ff;
   logic                     rsp_valid_ff;
   logic [1:0]               rsp_status_ff;
   logic [3:0]               rsp_entry_index_ff;
   logic                     rsp_removed_flag_ff;
   logic [3:0]               rsp_removed_index_ff;
   logic [4:0]               rsp_table_size_ff;
   logic [31:0]              rsp_entry_count_ff;

   logic [ENTRY_W-1:0]       rd_data;
   plane_entry_type          rd_ent;
   logic                     mem_we;
   logic [IDX_W-1:0]         mem_waddr;
   plane_entry_type          mem_wdata;
   plane_entry_type          ent_wb;
   plane_entry_type          ent_new;

   logic [1:0]               j;
   logic [1:0]               row;
   logic [3:0]               rot_idx;
   logic [1:0]               msel;
   logic signed [31:0]       e_c [3];
   logic signed [31:0]       e_n [3];
   logic signed [31:0]       t_j;
   logic signed [31:0]       old_v;
   logic signed [31:0]       new_v;
   logic signed [32:0]       op_a;
   logic signed [32:0]       op_b;
   logic signed [65:0]       mul_rnd;
   logic signed [51:0]       mac_sum;
   logic [51:0]              mac_abs;
   logic                     is_match;
   logic [32:0]              wsum_new;
   logic [34:0]              rem_sh;
   logic                     sub_ok;
   logic [34:0]              rem_sub;
   logic                     round_up;
   logic [64:0]              qv;
   logic signed [65:0]       sres;
   logic signed [31:0]       div_res;
   logic [63:0]              trial;
   logic                     sq_ge;
   logic [63:0]              res_nx;
   logic [32:0]              n_abs;
   logic [SIZE_W-1:0]        valid_m1;
   logic [SIZE_W-1:0]        valid_m2;

   gpmt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   assign rd_ent   = rd_data;
   assign valid_m1 = valid_ff - SIZE_W'(1);
   assign valid_m2 = valid_ff - SIZE_W'(2);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         e_c[k] = $signed(ent_ff.center[k]);
         e_n[k] = $signed(ent_ff.normal[k]);
      end
   end

   assign j       = cnt_ff[2:1];
   assign row     = (grp_ff < 3'd3) ? grp_ff[1:0] : 2'(grp_ff - 3'd3);
   assign rot_idx = 4'(row) * 4'd3 + 4'(j);
   assign msel    = (m_ff < 3'd3) ? m_ff[1:0] : 2'(m_ff - 3'd3);
   assign t_j     = sat32(68'(e_c[j]) - 68'(wc_ff[j]));
   assign old_v   = (m_ff < 3'd3) ? e_c[msel] : e_n[msel];
   assign new_v   = (m_ff < 3'd3) ? wc_ff[msel] : wn_ff[msel];

   always_comb begin
      case (state_ff)
         S_XFORM: begin
            op_a = 33'(rot_ff[rot_idx]);
            op_b = (grp_ff < 3'd3) ? 33'(vin_ff[j]) : 33'(vin_ff[3'(j) + 3'd3]);
         end
         S_MATCH: begin
            op_a = 33'(e_n[j]);
            op_b = (grp_ff == 3'd0) ? 33'(t_j) : 33'(wn_ff[j]);
         end
         S_BMUL: begin
            op_a = 33'(new_v) - 33'(old_v);
            op_b = $signed({2'b00, np_ff});
         end
         S_SQ: begin
            op_a = 33'(e_n[j]);
            op_b = 33'(e_n[j]);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign mul_rnd  = (mul_ff + 66'sd32768) >>> 16;
   assign mac_sum  = acc_ff + 52'(mul_rnd);
   assign mac_abs  = (mac_sum < 0) ? $unsigned(-mac_sum) : $unsigned(mac_sum);
   assign is_match = (dist_ff < 52'(md_ff)) && (mac_abs > 52'(mc_ff));
   assign wsum_new = 33'(np_ff) + 33'(ent_ff.points);

   assign rem_sh   = {div_r_ff, div_q_ff[63]};
   assign sub_ok   = rem_sh >= {1'b0, div_d_ff};
   assign rem_sub  = rem_sh - {1'b0, div_d_ff};
   assign round_up = div_neg_ff ? ({div_r_ff, 1'b0} > {1'b0, div_d_ff})
                                : ({div_r_ff, 1'b0} >= {1'b0, div_d_ff});
   assign qv       = {1'b0, div_q_ff} + 65'(round_up);
   assign sres     = div_neg_ff ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
   assign div_res  = sat32(68'(base_ff) + 68'(sres));

   assign trial    = res_ff + bit_ff;
   assign sq_ge    = sq_ff >= trial;
   assign res_nx   = sq_ge ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);
   assign n_abs    = (e_n[m_ff[1:0]] < 0) ? 33'(-33'(e_n[m_ff[1:0]]))
                                          : 33'(e_n[m_ff[1:0]]);

   always_comb begin
      ent_wb = ent_ff;
      if (ent_ff.points <= COUNT_CAP) begin
         ent_wb.points = ent_ff.points + 32'(np_ff);
      end
      ent_new.points = 32'(np_ff);
      for (int k = 0; k < 3; k++) begin
         ent_new.center[k] = wc_ff[k];
         ent_new.normal[k] = wn_ff[k];
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = ent_wb;
      case (state_ff)
         S_WB: begin
            mem_we = 1'b1;
         end
         S_APPEND: begin
            mem_we    = valid_ff != SIZE_W'(TABLE_DEPTH);
            mem_waddr = IDX_W'(valid_ff);
            mem_wdata = ent_new;
         end
         S_EWR: begin
            mem_we    = 1'b1;
            mem_waddr = IDX_W'(valid_m2);
            mem_wdata = rd_ent;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         md_ff        <= 31'd3932;
         mc_ff        <= 17'd64540;
         oc_ff        <= 31'd10000;
         for (int k = 0; k < 9; k++) begin
            rot_ff[k] <= (k % 4 == 0) ? 32'sd65536 : 32'sd0;
         end
         for (int k = 0; k < 3; k++) begin
            trans_ff[k] <= '0;
         end
      end else begin
         mul_ff <= op_a * op_b;
         if (csr_valid) begin
            case (csr_index)
               CSR_MATCH_DIST: md_ff <= csr_data[30:0];
               CSR_MATCH_COS:  mc_ff <= csr_data[16:0];
               CSR_OUTLIER:    oc_ff <= csr_data[30:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  idx_ff     <= '0;
                  rem_ff     <= 1'b0;
                  rem_idx_ff <= '0;
                  ecount_ff  <= '0;
                  np_ff      <= req_point_count;
                  vin_ff[0]  <= req_value_a;
                  vin_ff[1]  <= req_value_b;
                  vin_ff[2]  <= req_value_c;
                  vin_ff[3]  <= req_value_d;
                  vin_ff[4]  <= req_value_e;
                  vin_ff[5]  <= req_value_f;
                  grp_ff     <= '0;
                  cnt_ff     <= '0;
                  acc_ff     <= 52'(trans_ff[0]);
                  if (!req_kind) begin
                     if (req_pose_row != 2'd3) begin
                        rot_ff[4'(req_pose_row) * 4'd3]         <= req_value_a;
                        rot_ff[4'(req_pose_row) * 4'd3 + 4'd1]  <= req_value_b;
                        rot_ff[4'(req_pose_row) * 4'd3 + 4'd2]  <= req_value_c;
                        trans_ff[req_pose_row]                  <= req_value_d;
                     end
                     status_ff <= ST_POSE;
                     state_ff  <= S_DONE;
                  end else begin
                     state_ff <= S_XFORM;
                  end
               end
            end
            S_XFORM: begin
               if (cnt_ff[0]) begin
                  if (j == 2'd2) begin
                     if (grp_ff < 3'd3) begin
                        wc_ff[row] <= sat32(68'(mac_sum));
                     end else begin
                        wn_ff[row] <= sat32(68'(mac_sum));
                     end
                     acc_ff <= (grp_ff < 3'd2) ? 52'(trans_ff[row + 2'd1]) : '0;
                     grp_ff <= grp_ff + 3'd1;
                     cnt_ff <= '0;
                     if (grp_ff == 3'd5) begin
                        rd_addr_ff <= '0;
                        state_ff   <= (valid_ff == '0) ? S_APPEND : S_SCAN_RD;
                     end
                  end else begin
                     acc_ff <= mac_sum;
                     cnt_ff <= cnt_ff + 3'd1;
                  end
               end else begin
                  cnt_ff <= cnt_ff + 3'd1;
               end
            end
            S_SCAN_RD: begin
               state_ff <= S_SCAN_LD;
            end
            S_SCAN_LD: begin
               ent_ff   <= rd_ent;
               grp_ff   <= '0;
               cnt_ff   <= '0;
               acc_ff   <= '0;
               state_ff <= S_MATCH;
            end
            S_MATCH: begin
               if (cnt_ff[0]) begin
                  if (j == 2'd2) begin
                     acc_ff <= '0;
                     cnt_ff <= '0;
                     if (grp_ff == 3'd0) begin
                        dist_ff <= mac_abs;
                        grp_ff  <= 3'd1;
                     end else if (is_match) begin
                        status_ff <= ST_MERGE;
                        wsum_ff   <= wsum_new;
                        m_ff      <= '0;
                        state_ff  <= (wsum_new == '0) ? S_WB : S_BMUL;
                     end else if ((SIZE_W'(idx_ff) + SIZE_W'(1)) < valid_ff) begin
                        idx_ff     <= idx_ff + IDX_W'(1);
                        rd_addr_ff <= idx_ff + IDX_W'(1);
                        state_ff   <= S_SCAN_RD;
                     end else begin
                        state_ff <= S_APPEND;
                     end
                  end else begin
                     acc_ff <= mac_sum;
                     cnt_ff <= cnt_ff + 3'd1;
                  end
               end else begin
                  cnt_ff <= cnt_ff + 3'd1;
               end
            end
            S_BMUL: begin
               state_ff <= S_BDIVS;
            end
            S_BDIVS: begin
               div_neg_ff <= mul_ff < 0;
               div_q_ff   <= (mul_ff < 0) ? 64'(-mul_ff) : 64'(mul_ff);
               div_r_ff   <= '0;
               div_d_ff   <= {1'b0, wsum_ff};
               base_ff    <= old_v;
               norm_ff    <= 1'b0;
               it_ff      <= '0;
               state_ff   <= S_DIV;
            end
            S_DIV: begin
               div_q_ff <= {div_q_ff[62:0], sub_ok};
               div_r_ff <= sub_ok ? rem_sub[33:0] : rem_sh[33:0];
               it_ff    <= it_ff + 6'd1;
               if (it_ff == 6'd63) begin
                  state_ff <= S_DIVFIN;
               end
            end
            S_DIVFIN: begin
               if (!norm_ff) begin
                  if (m_ff < 3'd3) begin
                     ent_ff.center[msel] <= div_res;
                  end else begin
                     ent_ff.normal[msel] <= div_res;
                  end
                  m_ff <= m_ff + 3'd1;
                  if (m_ff == 3'd5) begin
                     cnt_ff   <= '0;
                     sq_ff    <= '0;
                     state_ff <= S_SQ;
                  end else begin
                     state_ff <= S_BMUL;
                  end
               end else begin
                  ent_ff.normal[m_ff[1:0]] <= div_res;
                  m_ff     <= m_ff + 3'd1;
                  state_ff <= (m_ff == 3'd2) ? S_WB : S_NSET;
               end
            end
            S_SQ: begin
               cnt_ff <= cnt_ff + 3'd1;
               if (cnt_ff[0]) begin
                  sq_ff <= sq_ff + mul_ff[63:0];
                  if (j == 2'd2) begin
                     res_ff   <= '0;
                     bit_ff   <= 64'd1 << 62;
                     it_ff    <= '0;
                     state_ff <= S_SQRT;
                  end
               end
            end
            S_SQRT: begin
               if (sq_ge) begin
                  sq_ff <= sq_ff - trial;
               end
               res_ff <= res_nx;
               bit_ff <= bit_ff >> 2;
               it_ff  <= it_ff + 6'd1;
               if (it_ff == 6'd31) begin
                  m_ff     <= '0;
                  state_ff <= (res_nx == '0) ? S_WB : S_NSET;
               end
            end
            S_NSET: begin
               div_neg_ff <= e_n[m_ff[1:0]] < 0;
               div_q_ff   <= 64'(n_abs) << 16;
               div_r_ff   <= '0;
               div_d_ff   <= res_ff[33:0];
               base_ff    <= '0;
               norm_ff    <= 1'b1;
               it_ff      <= '0;
               state_ff   <= S_DIV;
            end
            S_WB: begin
               ecount_ff <= ent_wb.points;
               state_ff  <= S_ORD;
            end
            S_APPEND: begin
               if (valid_ff == SIZE_W'(TABLE_DEPTH)) begin
                  idx_ff    <= '0;
                  status_ff <= ST_DROP;
                  state_ff  <= S_DONE;
               end else begin
                  idx_ff    <= IDX_W'(valid_ff);
                  valid_ff  <= valid_ff + SIZE_W'(1);
                  ecount_ff <= 32'(np_ff);
                  status_ff <= ST_APPEND;
                  state_ff  <= S_ORD;
               end
            end
            S_ORD: begin
               rd_addr_ff <= IDX_W'(valid_m2);
               state_ff   <= (valid_ff < SIZE_W'(2)) ? S_DONE : S_OWAIT;
            end
            S_OWAIT: begin
               state_ff <= S_OCHK;
            end
            S_OCHK: begin
               if (rd_ent.points < 32'(oc_ff)) begin
                  rem_ff     <= 1'b1;
                  rem_idx_ff <= IDX_W'(valid_m2);
                  rd_addr_ff <= IDX_W'(valid_m1);
                  state_ff   <= S_EWAIT;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_EWAIT: begin
               state_ff <= S_EWR;
            end
            S_EWR: begin
               valid_ff <= valid_m1;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_status_ff        <= status_ff;
                  rsp_entry_index_ff   <= 4'(idx_ff);
                  rsp_removed_flag_ff  <= rem_ff;
                  rsp_removed_index_ff <= 4'(rem_idx_ff);
                  rsp_table_size_ff    <= 5'(valid_ff);
                  rsp_entry_count_ff   <= ecount_ff;
                  state_ff             <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready         = state_ff == S_IDLE;
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_index   = rsp_entry_index_ff;
   assign rsp_removed_flag  = rsp_removed_flag_ff;
   assign rsp_removed_index = rsp_removed_index_ff;
   assign rsp_table_size    = rsp_table_size_ff;
   assign rsp_entry_count   = rsp_entry_count_ff;

   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff <= SIZE_W'(TABLE_DEPTH))
      else $error("table size beyond depth");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second word taken while busy");

   a_drop_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_DROP || rsp_status == ST_POSE))
      |-> (!rsp_removed_flag && rsp_entry_count == '0))
      else $error("drop or pose word carries entry data");

endmodule
`default_nettype wire

// ----- tb/ground_plane_merge_table_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ground_plane_merge_table_checker
// Watches the request, result and register channels of the plane merge
// table, keeps its own copy of the pose, table and thresholds, predicts the
// result word of every accepted request and compares it field by field with
// the result words in order. Reports the failure count and the number of
// result words still outstanding.
// ----------------------------------------------------------------------------
module ground_plane_merge_table_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic               req_kind,
   input  wire logic [1:0]         req_pose_row,
   input  wire logic signed [31:0] req_value_a,
   input  wire logic signed [31:0] req_value_b,
   input  wire logic signed [31:0] req_value_c,
   input  wire logic signed [31:0] req_value_d,
   input  wire logic signed [31:0] req_value_e,
   input  wire logic signed [31:0] req_value_f,
   input  wire logic [30:0]        req_point_count,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic [1:0]         rsp_status,
   input  wire logic [3:0]         rsp_entry_index,
   input  wire logic               rsp_removed_flag,
   input  wire logic [3:0]         rsp_removed_index,
   input  wire logic [4:0]         rsp_table_size,
   input  wire logic [31:0]        rsp_entry_count,
   input  wire logic               csr_valid,
   input  wire logic               csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data,
   output int                      fail_count,
   output int                      pending
);

   import gpmt_pkg::*;

   typedef struct {
      logic [1:0]  status;
      logic [3:0]  entry_index;
      logic        removed_flag;
      logic [3:0]  removed_index;
      logic [4:0]  table_size;
      logic [31:0] entry_count;
   } merge_result_type;

   merge_result_type   outstanding_q[$];
   logic signed [31:0] rot[9];
   logic signed [31:0] trans[3];
   logic signed [31:0] cen[TABLE_DEPTH][3];
   logic signed [31:0] nrm[TABLE_DEPTH][3];
   logic [31:0]        pts[TABLE_DEPTH];
   int                 nvalid;
   logic [30:0]        match_dist;
   logic [16:0]        match_cos;
   logic [30:0]        outlier_min;

   assign pending = outstanding_q.size();

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic longint qmul(logic signed [31:0] a, logic signed [31:0] b);
      return (longint'(a) * longint'(b) + 32768) >>> 16;
   endfunction

   function automatic longint round_div(longint num, longint unsigned den);
      longint unsigned mag, q, r;
      if (num >= 0) begin
         mag = num;
         q = mag / den;
         r = mag % den;
         return longint'(q) + ((2 * r >= den) ? 1 : 0);
      end
      mag = -(num + 1);
      mag = mag + 1;
      q = mag / den;
      r = mag % den;
      return -longint'(q) - ((2 * r > den) ? 1 : 0);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic logic signed [31:0] weighted_avg(logic signed [31:0] old_v,
         logic signed [31:0] new_v, longint unsigned wn, longint unsigned wsum);
      longint diff;
      diff = longint'(new_v) - longint'(old_v);
      return clamp32(longint'(old_v) + round_div(diff * longint'(wn), wsum));
   endfunction

   task automatic clear_state();
      for (int i = 0; i < 9; i++) rot[i] = 0;
      rot[0] = 65536;
      rot[4] = 65536;
      rot[8] = 65536;
      for (int i = 0; i < 3; i++) trans[i] = 0;
      nvalid = 0;
      match_dist = 31'd3932;
      match_cos = 17'd64540;
      outlier_min = 31'd10000;
      outstanding_q.delete();
   endtask

   task automatic predict_merge();
      logic signed [31:0] v[6];
      logic signed [31:0] c[3], n[3];
      logic [31:0]        np;
      longint             sc, sn, ang, ofs;
      longint unsigned    wsum, sq, len;
      merge_result_type   e;
      bit                 found;
      int                 k;
      v = '{req_value_a, req_value_b, req_value_c, req_value_d, req_value_e, req_value_f};
      np = {1'b0, req_point_count};
      e = '{ST_POSE, 4'd0, 1'b0, 4'd0, 5'd0, 32'd0};
      found = 0;
      if (req_kind == 1'b0) begin
         if (req_pose_row != 2'd3) begin
            for (int j = 0; j < 3; j++) rot[req_pose_row * 3 + j] = v[j];
            trans[req_pose_row] = v[3];
         end
      end else begin
         for (int r = 0; r < 3; r++) begin
            sc = trans[r];
            sn = 0;
            for (int j = 0; j < 3; j++) begin
               sc += qmul(rot[r * 3 + j], v[j]);
               sn += qmul(rot[r * 3 + j], v[3 + j]);
            end
            c[r] = clamp32(sc);
            n[r] = clamp32(sn);
         end
         for (int i = 0; i < nvalid && !found; i++) begin
            ang = 0;
            ofs = 0;
            for (int j = 0; j < 3; j++) begin
               ang += qmul(nrm[i][j], n[j]);
               ofs += qmul(nrm[i][j], clamp32(longint'(cen[i][j]) - longint'(c[j])));
            end
            if (ofs < 0) ofs = -ofs;
            if (ang < 0) ang = -ang;
            if (ofs < longint'(match_dist) && ang > longint'(match_cos)) begin
               found = 1;
               e.entry_index = 4'(i);
            end
         end
         if (found) begin
            k = int'(e.entry_index);
            e.status = ST_MERGE;
            wsum = longint'(np) + longint'(pts[k]);
            if (wsum != 0) begin
               sq = 0;
               for (int j = 0; j < 3; j++) begin
                  cen[k][j] = weighted_avg(cen[k][j], c[j], np, wsum);
                  nrm[k][j] = weighted_avg(nrm[k][j], n[j], np, wsum);
                  sq += longint'(nrm[k][j]) * longint'(nrm[k][j]);
               end
               len = int_sqrt(sq);
               if (len != 0) begin
                  for (int j = 0; j < 3; j++)
                     nrm[k][j] = clamp32(round_div(longint'(nrm[k][j]) * 65536, len));
               end
               if (pts[k] <= COUNT_CAP) pts[k] = pts[k] + np;
            end
            e.entry_count = pts[k];
         end else if (nvalid < TABLE_DEPTH) begin
            e.status = ST_APPEND;
            e.entry_index = 4'(nvalid);
            cen[nvalid] = c;
            nrm[nvalid] = n;
            pts[nvalid] = np;
            e.entry_count = np;
            nvalid++;
         end else begin
            e.status = ST_DROP;
         end
         if (e.status != ST_DROP && nvalid >= 2) begin
            k = nvalid - 2;
            if (pts[k] < {1'b0, outlier_min}) begin
               for (int i = k; i + 1 < nvalid; i++) begin
                  cen[i] = cen[i + 1];
                  nrm[i] = nrm[i + 1];
                  pts[i] = pts[i + 1];
               end
               nvalid--;
               e.removed_flag = 1'b1;
               e.removed_index = 4'(k);
            end
         end
      end
      e.table_size = 5'(nvalid);
      outstanding_q.insert(outstanding_q.size(), e);
   endtask

   task automatic check_result();
      merge_result_type e;
      if (outstanding_q.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: unexpected result word status=%0d", $realtime, rsp_status);
         return;
      end
      e = outstanding_q.pop_front();
      if (rsp_status !== e.status || rsp_entry_index !== e.entry_index ||
          rsp_removed_flag !== e.removed_flag || rsp_removed_index !== e.removed_index ||
          rsp_table_size !== e.table_size || rsp_entry_count !== e.entry_count) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: mismatch exp st=%0d idx=%0d rm=%0d/%0d size=%0d cnt=%0d got st=%0d idx=%0d rm=%0d/%0d size=%0d cnt=%0d",
                     $realtime, e.status, e.entry_index, e.removed_flag, e.removed_index,
                     e.table_size, e.entry_count, rsp_status, rsp_entry_index,
                     rsp_removed_flag, rsp_removed_index, rsp_table_size, rsp_entry_count);
      end
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MATCH_DIST: match_dist = csr_data[30:0];
               CSR_MATCH_COS:  match_cos = csr_data[16:0];
               CSR_OUTLIER:    outlier_min = csr_data[30:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_merge();
         if (rsp_valid && rsp_ready) check_result();
      end
   end

endmodule
`default_nettype wire

// ----- tb/tb_ground_plane_merge_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_ground_plane_merge_table
// Drives pose and plane words into the ground plane merge table: a directed
// opening (saturation, merge, zero weight, zero normal, count cap, outlier
// erase, ignored pose row) and then clustered random planes around twenty
// prototype planes with some noise, over several threshold settings. Both
// sides idle at random. The checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_ground_plane_merge_table;
   import gpmt_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_kind;
   logic [1:0]         req_pose_row;
   logic signed [31:0] req_value_a, req_value_b, req_value_c;
   logic signed [31:0] req_value_d, req_value_e, req_value_f;
   logic [30:0]        req_point_count;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [1:0]         rsp_status;
   logic [3:0]         rsp_entry_index;
   logic               rsp_removed_flag;
   logic [3:0]         rsp_removed_index;
   logic [4:0]         rsp_table_size;
   logic [31:0]        rsp_entry_count;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [31:0]        csr_data;
   int                 fail_count;
   int                 pending;
   int                 idle_cycles;
   int                 rsp_hold;
   bit                 quiet;

   ground_plane_merge_table u_top (.*);

   ground_plane_merge_table_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int draw_gap();
      if (quiet || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 15);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if (rsp_valid && rsp_ready) begin
         rsp_hold <= draw_gap();
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[ground_plane_merge_table] ERROR");
         $finish;
      end
   end

   task automatic send_word(logic kind, logic [1:0] row, logic signed [31:0] a,
         logic signed [31:0] b, logic signed [31:0] c, logic signed [31:0] d,
         logic signed [31:0] e, logic signed [31:0] f, logic [30:0] cnt);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_pose_row <= row;
      req_value_a <= a;
      req_value_b <= b;
      req_value_c <= c;
      req_value_d <= d;
      req_value_e <= e;
      req_value_f <= f;
      req_point_count <= cnt;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic pose_row(logic [1:0] row, logic signed [31:0] a, logic signed [31:0] b,
         logic signed [31:0] c, logic signed [31:0] t);
      send_word(1'b0, row, a, b, c, t, $urandom, $urandom, 31'($urandom));
   endtask

   task automatic plane(logic signed [31:0] cx, logic signed [31:0] cy,
         logic signed [31:0] cz, logic signed [31:0] nx, logic signed [31:0] ny,
         logic signed [31:0] nz, logic [30:0] cnt);
      send_word(1'b1, 2'($urandom_range(0, 3)), cx, cy, cz, nx, ny, nz, cnt);
   endtask

   task automatic random_word();
      logic signed [31:0] base[3], dir[3];
      logic signed [31:0] sgn;
      int                 k, sel, row;
      logic [30:0]        cnt;
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
         row = $urandom_range(0, 2);
         sgn = $urandom_range(0, 1) ? 65536 : -65536;
         pose_row(2'(row), row == 0 ? sgn : 0, row == 1 ? sgn : 0, row == 2 ? sgn : 0,
                  $signed($urandom_range(0, 4000)) - 2000);
      end else if (sel < 10) begin
         send_word(1'b0, 2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, 31'($urandom));
      end else if (sel < 18) begin
         send_word(1'b1, 2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, 31'($urandom));
      end else begin
         k = $urandom_range(0, 19);
         case (k % 4)
            0: dir = '{0, 0, 65536};
            1: dir = '{65536, 0, 0};
            2: dir = '{0, 46341, 46341};
            default: dir = '{37837, 37837, 37837};
         endcase
         for (int j = 0; j < 3; j++) begin
            base[j] = dir[j] * k + $signed($urandom_range(0, 2000)) - 1000;
            dir[j] = dir[j] + $signed($urandom_range(0, 600)) - 300;
         end
         case ($urandom_range(0, 9))
            0: cnt = '0;
            1: cnt = 31'($urandom);
            2, 3, 4, 5: cnt = 31'($urandom_range(0, 20000));
            default: cnt = 31'($urandom_range(10000, 2000000));
         endcase
         plane(base[0], base[1], base[2], dir[0], dir[1], dir[2], cnt);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = 1'b0;
      req_pose_row = 2'd0;
      req_value_a = 0;
      req_value_b = 0;
      req_value_c = 0;
      req_value_d = 0;
      req_value_e = 0;
      req_value_f = 0;
      req_point_count = 0;
      csr_valid = 1'b0;
      csr_index = CSR_MATCH_DIST;
      csr_data = 0;
      quiet = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      pose_row(2'd3, 32'sh80000000, 32'sh7fffffff, 32'shffffffff, 32'sh80000000);
      pose_row(2'd0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
      plane(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
            32'sh7fffffff, 31'h7fffffff);
      pose_row(2'd0, 65536, 0, 0, 0);
      plane(0, 0, 0, 0, 0, 65536, 20000);
      plane(100, -200, 500, 200, 0, 65530, 20000);
      plane(0, 0, 65536, 0, 0, 65536, 0);
      plane(0, 0, 65536, 0, 0, 65536, 0);
      plane(0, 0, 131072, 0, 0, 65536, 5);
      plane(0, 0, 262144, 0, 0, 65536, 100);
      plane(0, 0, 262144, 0, 0, -65536, 100);
      plane(0, 0, 0, 0, 0, 65536, 31'h7fffffff);
      plane(0, 0, 0, 0, 0, 65536, 31'h7fffffff);
      plane(0, 0, 0, 0, 0, 65536, 31'h7fffffff);
      pose_row(2'd2, 0, 0, -65536, 32'sh00010000);
      plane(0, 0, 0, 0, 0, 65536, 20000);
      pose_row(2'd2, 0, 0, 65536, 0);
      plane(0, 0, 0, 65536, 0, 0, 30000);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            1: begin
               write_reg(CSR_MATCH_DIST, 32'd0);
               write_reg(CSR_MATCH_COS, 32'd65536);
               write_reg(CSR_OUTLIER, 32'd0);
            end
            2: begin
               write_reg(CSR_MATCH_DIST, 32'hffffffff);
               write_reg(CSR_MATCH_COS, 32'd0);
               write_reg(CSR_OUTLIER, 32'hffffffff);
            end
            3: begin
               write_reg(CSR_MATCH_DIST, $urandom_range(1000, 20000));
               write_reg(CSR_MATCH_COS, $urandom_range(40000, 65536));
               write_reg(CSR_OUTLIER, $urandom_range(0, 30000));
            end
            default: ;
         endcase
         for (int n = 0; n < 260; n++) begin
            if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
            random_word();
         end
         drain();
      end

      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ground_plane_merge_table] OK");
      end else begin
         $display("[ground_plane_merge_table] ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ----- files.f -----
hdl/gpmt_pkg.sv
hdl/gpmt_ram.sv
hdl/ground_plane_merge_table.sv
tb/ground_plane_merge_table_checker.sv
tb/tb_ground_plane_merge_table.sv
